### rtl/strl_pkg.sv
`default_nettype none

package strl_pkg;

    // field widths
    localparam int ID_W   = 16;
    localparam int TIME_W = 32;
    localparam int WIN_W  = 16;
    localparam int POS_W  = 16;
    localparam int PAN_W  = 16;
    localparam int SLOT_W = 6;

    // pan dividend: 256 * position_x + map width, below 2^24 for map widths below 256
    localparam int NUM_W = POS_W + 8;

    // q1.14 unity and the saturated full-right quotient
    localparam logic [PAN_W-1:0] PAN_ONE  = 16'd16384;
    localparam logic [PAN_W-1:0] PAN_FULL = 16'd32768;

    localparam logic [WIN_W-1:0] WINDOW_RESET = 16'd50;

    // input transaction
    typedef struct packed {
        logic [ID_W-1:0]   sound_id;
        logic [TIME_W-1:0] now_ms;
        logic              has_position;
        logic [POS_W-1:0]  position_x;
    } t_req;

    // result transaction
    typedef struct packed {
        logic                    played;
        logic [ID_W-1:0]         play_id;
        logic signed [PAN_W-1:0] pan;
        logic [SLOT_W-1:0]       slot_used;
    } t_res;

endpackage

`default_nettype wire

### rtl/sound_trigger_rate_limiter.sv
`default_nettype none

// Sound trigger rate limiter. A trigger is taken when start is high and busy is
// low; its one result shows on o_res for a single cycle with o_done high and
// cannot be held off. A trigger whose id sits in a slot played within the
// repeat window is dropped; otherwise the slot with the oldest time (lowest
// index on ties) is overwritten and a play with its q1.14 pan is reported.
// Each trigger's result strobe follows the slot scan: one slot is read from the
// slot memory per cycle, each read is registered and then evaluated, and the
// result is registered after the last slot. The pan quotient comes from a
// reciprocal multiply registered when the trigger is accepted. busy drops in
// the cycle the result is shown, so a new trigger can be taken only once the
// last one's result is shown. The window register is written through the cfg
// channel, which is always ready; write it only while idle.
module sound_trigger_rate_limiter #(
    parameter int SLOTS     = 8,
    parameter int MAP_WIDTH = 32
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire strl_pkg::t_req             i_req,
    output logic                            o_done,
    output strl_pkg::t_res                  o_res,
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic [strl_pkg::WIN_W-1:0] i_cfg_data
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WAIT
    } t_state;

    t_state r_state;

    logic [strl_pkg::WIN_W-1:0]  r_window;
    strl_pkg::t_req              r_req;
    logic [IW-1:0]               r_addr;
    logic                        r_iss_done;
    logic                        r_rd_pend;
    logic [IW-1:0]               r_ev_idx;
    logic                        r_match;
    logic [IW-1:0]               r_old_idx;
    logic [strl_pkg::TIME_W-1:0] r_old_time;

    // slot memory and its registered read port
    logic [strl_pkg::ID_W-1:0]   mem_sound [SLOTS];
    logic [strl_pkg::TIME_W-1:0] mem_time  [SLOTS];
    logic [SLOTS-1:0]            r_slot_vld;
    logic [strl_pkg::ID_W-1:0]   r_rd_sound;
    logic [strl_pkg::TIME_W-1:0] r_rd_time;
    logic                        r_rd_vld;

    logic                        accept;
    logic                        finish;
    logic                        wr_en;
    logic [strl_pkg::ID_W-1:0]   cur_sound;
    logic [strl_pkg::TIME_W-1:0] cur_time;
    logic [strl_pkg::TIME_W-1:0] age;
    logic                        hit;
    logic                        take_old;

    logic [strl_pkg::NUM_W-1:0]  div_num;
    logic [strl_pkg::NUM_W-1:0]  div_quot;
    logic [strl_pkg::PAN_W-1:0]  pan_sat;

    assign accept      = start && !busy;
    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign finish      = (r_state == S_WAIT);
    assign wr_en       = finish && !r_match;

    // compare unit: one slot per cycle, unwritten slots read as id 0 at time 0
    always_comb begin
        cur_sound = r_rd_vld ? r_rd_sound : '0;
        cur_time  = r_rd_vld ? r_rd_time  : '0;
        age       = r_req.now_ms - cur_time;
        hit       = (cur_sound == r_req.sound_id) &&
                    (age <= strl_pkg::TIME_W'(r_window));
        take_old  = (r_ev_idx == '0) || (cur_time < r_old_time);
    end

    // pan = round(128 * x / width) - 1.0, saturated at full right
    assign div_num = {i_req.position_x, 8'h00} + strl_pkg::NUM_W'(MAP_WIDTH);
    assign pan_sat = (div_quot > strl_pkg::NUM_W'(strl_pkg::PAN_FULL)) ?
                     strl_pkg::PAN_FULL : div_quot[strl_pkg::PAN_W-1:0];

    strl_div #(
        .MAP_WIDTH (MAP_WIDTH)
    ) u_div (
        .i_clk   (i_clk),
        .i_start (accept),
        .i_num   (div_num),
        .o_quot  (div_quot)
    );

    // slot memory: read the scan address, write the chosen slot at the end
    always_ff @(posedge i_clk) begin
        r_rd_sound <= mem_sound[r_addr];
        r_rd_time  <= mem_time[r_addr];
        r_rd_vld   <= r_slot_vld[r_addr];
        r_ev_idx   <= r_addr;
        if (wr_en) begin
            mem_sound[r_old_idx] <= r_req.sound_id;
            mem_time[r_old_idx]  <= r_req.now_ms;
        end
    end

    // slot valid bits, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_vld <= '0;
        end else if (wr_en) begin
            r_slot_vld[r_old_idx] <= 1'b1;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_window   <= strl_pkg::WINDOW_RESET;
            r_addr     <= '0;
            r_iss_done <= 1'b0;
            r_rd_pend  <= 1'b0;
            r_match    <= 1'b0;
            o_done     <= 1'b0;
        end else begin
            o_done    <= finish;
            r_rd_pend <= (r_state == S_SCAN) && !r_iss_done;
            if (i_cfg_valid && o_cfg_ready) begin
                r_window <= i_cfg_data;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_req      <= i_req;
                        r_addr     <= '0;
                        r_iss_done <= 1'b0;
                        r_match    <= 1'b0;
                        r_state    <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // issue reads
                    if (!r_iss_done) begin
                        if (r_addr == LAST) begin
                            r_iss_done <= 1'b1;
                        end else begin
                            r_addr <= r_addr + IW'(1);
                        end
                    end
                    // evaluate the slot read last cycle
                    if (r_rd_pend) begin
                        r_match <= r_match | hit;
                        if (take_old) begin
                            r_old_idx  <= r_ev_idx;
                            r_old_time <= cur_time;
                        end
                        if (r_ev_idx == LAST) begin
                            r_state <= S_WAIT;
                        end
                    end
                end
                S_WAIT: begin
                    o_res.played    <= !r_match;
                    o_res.play_id   <= r_req.sound_id;
                    o_res.pan       <= (!r_match && r_req.has_position) ?
                                       signed'(pan_sat - strl_pkg::PAN_ONE) : '0;
                    o_res.slot_used <= r_match ? '0 :
                                       strl_pkg::SLOT_W'(r_old_idx);
                    r_addr          <= '0;
                    r_state         <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### rtl/strl_div.sv
`default_nettype none

// pan quotient by the constant 2 * MAP_WIDTH through a reciprocal multiply,
// exact for every dividend below 2^NUM_W, registered on start
module strl_div #(
    parameter int MAP_WIDTH = 32
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_start,
    input  wire logic [strl_pkg::NUM_W-1:0] i_num,
    output logic [strl_pkg::NUM_W-1:0]      o_quot
);

    localparam int DIVISOR = 2 * MAP_WIDTH;
    localparam int SH      = strl_pkg::NUM_W + $clog2(DIVISOR);
    localparam longint unsigned RECIP =
        ((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam int RW      = strl_pkg::NUM_W + 2;
    localparam int PW      = strl_pkg::NUM_W + RW;

    logic [PW-1:0]              prod;
    logic [strl_pkg::NUM_W-1:0] r_q;

    // dividend times the rounded-up reciprocal, quotient in the high bits
    assign prod = PW'(i_num) * PW'(RECIP);

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q <= strl_pkg::NUM_W'(prod >> SH);
        end
    end

    assign o_quot = r_q;

endmodule

`default_nettype wire

### verif/sound_trigger_rate_limiter_checker.sv
`timescale 1ns / 1ps

module sound_trigger_rate_limiter_checker #(
    parameter int SLOTS     = 8,
    parameter int MAP_WIDTH = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic                       i_busy,
    input  strl_pkg::t_req             i_req,
    input  logic                       i_done,
    input  strl_pkg::t_res             i_res,
    input  logic                       i_cfg_valid,
    input  logic                       i_cfg_ready,
    input  logic [strl_pkg::WIN_W-1:0] i_cfg_data,
    output int                         o_pending,
    output int                         o_errors
);

    // shadow copy of the slot table and the repeat window
    logic [strl_pkg::ID_W-1:0]   shadow_id    [SLOTS];
    logic [strl_pkg::TIME_W-1:0] shadow_stamp [SLOTS];
    logic [strl_pkg::WIN_W-1:0]  shadow_window;
    strl_pkg::t_res              expected_plays [$];
    int                          mismatches = 0;

    // q1.14 pan: round half up of 128 * x / width, saturated at full right, less 1.0; zero without a position
    function automatic logic [strl_pkg::PAN_W-1:0] pan_for(
        logic has_pos, logic [strl_pkg::POS_W-1:0] pos_x);
        logic [31:0] quotient;
        if (!has_pos) begin
            return '0;
        end
        quotient = ((32'(pos_x) << 8) + 32'(MAP_WIDTH)) / 32'(2 * MAP_WIDTH);
        if (quotient > 32'(strl_pkg::PAN_FULL)) begin
            quotient = 32'(strl_pkg::PAN_FULL);
        end
        return quotient[strl_pkg::PAN_W-1:0] - strl_pkg::PAN_ONE;
    endfunction

    // repeat filter and oldest-slot replacement, updates the shadow table
    function automatic strl_pkg::t_res play_decision(strl_pkg::t_req trig);
        strl_pkg::t_res outcome;
        int             oldest;
        logic [31:0]    age;
        oldest = 0;
        outcome = '0;
        outcome.play_id = trig.sound_id;
        for (int i = 0; i < SLOTS; i++) begin
            if (shadow_stamp[i] < shadow_stamp[oldest]) begin
                oldest = i;
            end
            age = trig.now_ms - shadow_stamp[i];
            if (shadow_id[i] == trig.sound_id && age <= {16'd0, shadow_window}) begin
                return outcome;
            end
        end
        shadow_stamp[oldest] = trig.now_ms;
        shadow_id[oldest]    = trig.sound_id;
        outcome.played    = 1'b1;
        outcome.pan       = pan_for(trig.has_position, trig.position_x);
        outcome.slot_used = strl_pkg::SLOT_W'(oldest);
        return outcome;
    endfunction

    // watch the three channels at each rising edge
    always @(posedge i_clk) begin
        strl_pkg::t_res want;
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                shadow_id[i]    = '0;
                shadow_stamp[i] = '0;
            end
            shadow_window = strl_pkg::WINDOW_RESET;
            expected_plays.delete();
        end else begin
            // result transaction against the oldest expectation
            if (i_done) begin
                if (expected_plays.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("[%0t] unexpected result: played=%0b id=%0h pan=%0d slot=%0d",
                                 $realtime, i_res.played, i_res.play_id, i_res.pan,
                                 i_res.slot_used);
                    end
                end else begin
                    want = expected_plays.pop_front();
                    if (i_res.played !== want.played || i_res.play_id !== want.play_id ||
                        i_res.pan !== want.pan || i_res.slot_used !== want.slot_used) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("[%0t] result mismatch: exp played=%0b id=%0h pan=%0d slot=%0d",
                                     $realtime, want.played, want.play_id, want.pan,
                                     want.slot_used);
                            $display("[%0t]                  got played=%0b id=%0h pan=%0d slot=%0d",
                                     $realtime, i_res.played, i_res.play_id, i_res.pan,
                                     i_res.slot_used);
                        end
                    end
                end
            end
            // accepted trigger transaction
            if (i_start && !i_busy) begin
                expected_plays.push_back(play_decision(i_req));
            end
            // window register write
            if (i_cfg_valid && i_cfg_ready) begin
                shadow_window = i_cfg_data;
            end
        end
        o_pending = expected_plays.size();
        o_errors  = mismatches;
    end

endmodule

### verif/tb_sound_trigger_rate_limiter.sv
`timescale 1ns / 1ps

module tb_sound_trigger_rate_limiter;

    localparam int SLOTS        = 8;
    localparam int MAP_WIDTH    = 32;
    localparam int SETTLE       = 40;
    localparam int PHASE_ITEMS  = 250;
    localparam int CYCLE_LIMIT  = 400000;

    logic                       clk;
    logic                       rst_n;
    logic                       start;
    logic                       busy;
    strl_pkg::t_req             trig;
    logic                       done;
    strl_pkg::t_res             res;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [strl_pkg::WIN_W-1:0] cfg_data;
    int                         pending;
    int                         errors;
    int                         cycles = 0;

    // stimulus state
    logic [strl_pkg::TIME_W-1:0] clock_ms;
    logic [strl_pkg::WIN_W-1:0]  window_now;
    logic                        idle_on;
    int                          sent;

    sound_trigger_rate_limiter #(
        .SLOTS    (SLOTS),
        .MAP_WIDTH(MAP_WIDTH)
    ) u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .start      (start),
        .busy       (busy),
        .i_req      (trig),
        .o_done     (done),
        .o_res      (res),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_data (cfg_data)
    );

    sound_trigger_rate_limiter_checker #(
        .SLOTS    (SLOTS),
        .MAP_WIDTH(MAP_WIDTH)
    ) u_checker (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_start    (start),
        .i_busy     (busy),
        .i_req      (trig),
        .i_done     (done),
        .i_res      (res),
        .i_cfg_valid(cfg_valid),
        .i_cfg_ready(cfg_ready),
        .i_cfg_data (cfg_data),
        .o_pending  (pending),
        .o_errors   (errors)
    );

    // 12 ns clock
    initial clk = 1'b0;
    always #6 clk = ~clk;

    // run watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // one trigger transaction, then a random pause before the next one
    task automatic send_trigger(input logic [strl_pkg::ID_W-1:0] id,
                                input logic [strl_pkg::TIME_W-1:0] now,
                                input logic has_pos,
                                input logic [strl_pkg::POS_W-1:0] pos_x);
        int gap;
        start              <= 1'b1;
        trig.sound_id      <= id;
        trig.now_ms        <= now;
        trig.has_position  <= has_pos;
        trig.position_x    <= pos_x;
        forever begin
            @(posedge clk);
            if (!busy) break;
        end
        @(negedge clk);
        sent++;
        if (sent % 50 == 0) begin
            idle_on = ($urandom_range(0, 3) != 0);
        end
        gap = idle_on ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // mostly repeats from a small id pool around the window edge, some noise
    task automatic send_random_trigger();
        int                          pick;
        logic [strl_pkg::ID_W-1:0]   id;
        logic                        has_pos;
        logic [strl_pkg::POS_W-1:0]  pos_x;
        pick = $urandom_range(0, 99);
        id = (pick < 80) ? strl_pkg::ID_W'($urandom_range(0, 11)) :
                           strl_pkg::ID_W'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            clock_ms += $urandom_range(0, 2 * int'(window_now) + 2);
        end else if (pick < 85) begin
            clock_ms += $urandom_range(0, 3);
        end else if (pick < 95) begin
            clock_ms = $urandom;
        end else begin
            clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 200);
        end
        has_pos = ($urandom_range(0, 4) != 0);
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
            pos_x = strl_pkg::POS_W'($urandom);
        end else if (pick < 8) begin
            pos_x = strl_pkg::POS_W'($urandom_range(0, 8200));
        end else begin
            case ($urandom_range(0, 3))
                0: pos_x = '0;
                1: pos_x = 16'd8191;
                2: pos_x = 16'd8192;
                default: pos_x = 16'hFFFF;
            endcase
        end
        send_trigger(id, clock_ms, has_pos, pos_x);
    endtask

    // window write once all results are back
    task automatic write_window(input logic [strl_pkg::WIN_W-1:0] value);
        start <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        forever begin
            @(posedge clk);
            if (cfg_ready) break;
        end
        @(negedge clk);
        cfg_valid  <= 1'b0;
        window_now = value;
    endtask

    initial begin
        logic [strl_pkg::WIN_W-1:0] phase_window;
        sent       = 0;
        idle_on    = 1'b1;
        clock_ms   = '0;
        window_now = strl_pkg::WINDOW_RESET;
        rst_n      = 1'b0;
        start      = 1'b0;
        trig       = '0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: fresh slots, window edges, time wrap, pan extremes, replacement
        send_trigger(16'd0, 32'd0, 1'b0, 16'd0);
        send_trigger(16'd0, 32'd50, 1'b1, 16'h1234);
        send_trigger(16'd0, 32'd51, 1'b1, 16'd0);
        send_trigger(16'hFFFF, 32'hFFFF_FFFF, 1'b1, 16'hFFFF);
        send_trigger(16'hFFFF, 32'h0000_0010, 1'b0, 16'd0);
        send_trigger(16'hFFFF, 32'h0000_0031, 1'b1, 16'd4096);
        send_trigger(16'hFFFF, 32'h0000_0032, 1'b1, 16'd4096);
        send_trigger(16'd1, 32'd100, 1'b1, 16'd8192);
        send_trigger(16'd2, 32'd100, 1'b1, 16'd8191);
        send_trigger(16'd3, 32'd100, 1'b1, 16'd1);
        send_trigger(16'd4, 32'd100, 1'b0, 16'hFFFF);
        send_trigger(16'd5, 32'd100, 1'b1, 16'h8000);
        send_trigger(16'd6, 32'd200, 1'b1, 16'd2048);
        send_trigger(16'd1, 32'd150, 1'b1, 16'd100);
        send_trigger(16'd1, 32'd151, 1'b1, 16'd100);
        send_trigger(16'd7, 32'd151, 1'b1, 16'hAAAA);
        send_trigger(16'd7, 32'd151, 1'b1, 16'h5555);
        send_trigger(16'hA5A5, 32'h8000_0000, 1'b1, 16'd3);
        send_trigger(16'h5A5A, 32'h7FFF_FFFF, 1'b1, 16'd6000);
        send_trigger(16'd2, 32'd300, 1'b1, 16'd0);

        // random phases over several window settings, extremes first
        clock_ms = 32'd1000;
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: phase_window = '0;
                1: phase_window = 16'hFFFF;
                2: phase_window = strl_pkg::WIN_W'($urandom_range(1, 200));
                3: phase_window = strl_pkg::WINDOW_RESET;
                default: phase_window = strl_pkg::WIN_W'($urandom);
            endcase
            write_window(phase_window);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_random_trigger();
            end
        end

        // drain and give the verdict
        start <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
        if (errors == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
